>>> rtl/ctv_pkg.sv
// Shared types and constants for the chunk tree validator.
package ctv_pkg;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 4;
  localparam int OFF_W      = 33;
  localparam int HDR_LEN    = 16;
  localparam int ID_W       = 32;
  localparam int FLAG_W     = 16;
  localparam int SIZE_W     = 32;
  localparam int HDR_IDX_W  = 4;

  localparam logic [ID_W-1:0]      ROOT_ID      = 32'h8000_0001;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 4'd15;

  // Verdict codes, first violation wins
  typedef enum logic [KIND_W-1:0] {
    ERR_NONE       = 4'd0,
    ERR_ROOT_ID    = 4'd1,
    ERR_ROOT_HDR   = 4'd2,
    ERR_ID_BIT     = 4'd3,
    ERR_SIZE_HIGH  = 4'd4,
    ERR_CHILD_FLAG = 4'd5,
    ERR_OVERRUN    = 4'd6,
    ERR_HDR_CUT    = 4'd7,
    ERR_TOO_DEEP   = 4'd8,
    ERR_SHORT      = 4'd9,
    ERR_EXTRA      = 4'd10
  } err_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONSUME,
    ST_HDR_CHECK,
    ST_CLOSE,
    ST_CLOSE_LOAD,
    ST_FINAL
  } state_t;

endpackage

>>> rtl/chunk_tree_validator.sv
// Chunk tree validator: streams a file byte by byte and checks its nested chunk headers.
//
// One input beat is one file byte. An ordinary byte is accepted, then passes once through
// the shared adder/compare unit. The byte that completes a 16-byte header adds the header
// checks and, unless a leaf payload follows, a level-close compare, as does the last leaf
// payload byte. Each further level that ends there adds a reload and a compare (the level-end
// stack is a memory with a registered read, and levels are popped one per visit). A beat
// marked last adds a step to form the verdict, which then waits in the output register
// while the next file's bytes are already being accepted; a second verdict is held back
// until the first one is taken.
module chunk_tree_validator
  import ctv_pkg::*;
#(
  parameter int MAX_NESTING   = 32,
  parameter int POSITION_BITS = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  // input byte channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic              in_last_byte,
  // verdict channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic [KIND_W-1:0] out_error_kind,
  output logic [OFF_W-1:0]  out_error_offset
);

  localparam int P     = POSITION_BITS;
  localparam int LW    = $clog2(MAX_NESTING + 1);
  localparam int DEPTH = MAX_NESTING + 1;
  localparam int AW    = ((P > SIZE_W) ? P : SIZE_W) + 1;

  // sequencer and stream state
  state_t                 state_r, state_nxt;
  logic [P-1:0]           pos_r, pos_nxt;
  logic [HDR_IDX_W-1:0]   idx_r, idx_nxt;
  logic [P-1:0]           hdr_start_r, hdr_start_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [FLAG_W-1:0]      child_r, child_nxt;
  logic                   hi_nz_r, hi_nz_nxt;
  logic [SIZE_W-1:0]      size_r, size_nxt;
  logic                   in_leaf_r, in_leaf_nxt;
  logic [SIZE_W-1:0]      leaf_r, leaf_nxt;
  logic [LW-1:0]          open_r, open_nxt;
  logic [P-1:0]           top_r, top_nxt;
  err_kind_t              err_kind_r, err_kind_nxt;
  logic [P-1:0]           err_off_r, err_off_nxt;
  logic [BYTE_W-1:0]      byte_r, byte_nxt;
  logic                   last_r, last_nxt;

  // verdict register
  logic                   out_valid_r, out_valid_nxt;
  err_kind_t              out_kind_r, out_kind_nxt;
  logic [OFF_W-1:0]       out_off_r, out_off_nxt;

  // level-end stack
  logic [P-1:0]           stack_mem [DEPTH];
  logic                   mem_we;
  logic [LW-1:0]          mem_waddr;
  logic [P-1:0]           mem_wdata;
  logic [P-1:0]           rd_data_r;

  // shared adder/compare unit
  logic [AW-1:0]          alu_a, alu_b, alu_c, alu_sum;
  logic                   alu_gt, alu_eq;

  // decode signals
  logic                   pos_ge16, c_extra, c_cut, c_pop, is_root;
  logic                   root_fail, chunk_fail, push_ok, out_free, short_err;
  logic [P-1:0]           end_pos;
  err_kind_t              chunk_kind, final_kind;
  logic [P-1:0]           final_off;
  logic [OFF_W+P-1:0]     final_off_ext;

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    unique case (state_r)
      ST_CONSUME: begin
        if (in_leaf_r) begin
          alu_a = {{(AW-SIZE_W){1'b0}}, leaf_r};
          alu_b = '1;
        end else begin
          alu_a = {{(AW-P){1'b0}}, pos_r};
          alu_b = AW'(HDR_LEN);
          alu_c = {{(AW-P){1'b0}}, top_r};
        end
      end
      ST_HDR_CHECK: begin
        alu_a = {{(AW-P){1'b0}}, pos_r};
        alu_b = {{(AW-SIZE_W){1'b0}}, size_r};
        alu_c = {{(AW-P){1'b0}}, top_r};
      end
      ST_CLOSE: begin
        alu_a = {{(AW-P){1'b0}}, pos_r};
        alu_c = {{(AW-P){1'b0}}, top_r};
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;
  assign alu_gt  = alu_sum > alu_c;
  assign alu_eq  = alu_sum == alu_c;
  assign end_pos = alu_sum[P-1:0];

  // decode the checks of the current step
  assign pos_ge16   = |pos_r[P-1:4];
  assign is_root    = open_r == '0;
  assign c_extra    = is_root && (idx_r == '0) && pos_ge16;
  assign c_cut      = (idx_r == '0) && !is_root && alu_gt;
  assign c_pop      = !is_root && alu_eq;
  assign root_fail  = hi_nz_r || (child_r != FLAG_W'(1));
  assign push_ok    = open_r < LW'(MAX_NESTING);
  assign out_free   = !out_valid_r || !out_stall;
  assign short_err  = (err_kind_r == ERR_NONE) &&
                      !(is_root && (idx_r == '0) && !in_leaf_r && pos_ge16);

  // first failing chunk check, in priority order
  always_comb begin
    chunk_kind = ERR_NONE;
    if (!id_r[ID_W-1])                               chunk_kind = ERR_ID_BIT;
    else if (hi_nz_r)                                chunk_kind = ERR_SIZE_HIGH;
    else if (child_r > FLAG_W'(1))                   chunk_kind = ERR_CHILD_FLAG;
    else if (open_r > LW'(MAX_NESTING))              chunk_kind = ERR_TOO_DEEP;
    else if (alu_gt)                                 chunk_kind = ERR_OVERRUN;
    else if ((child_r == FLAG_W'(1)) && !push_ok)    chunk_kind = ERR_TOO_DEEP;
  end
  assign chunk_fail = chunk_kind != ERR_NONE;

  // verdict for the last byte
  assign final_kind    = short_err ? ERR_SHORT : err_kind_r;
  assign final_off     = short_err ? pos_r : err_off_r;
  assign final_off_ext = {{OFF_W{1'b0}}, final_off};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONSUME;
      end
      ST_CONSUME: begin
        state_nxt = last_r ? ST_FINAL : ST_IDLE;
        if (err_kind_r == ERR_NONE && !c_extra) begin
          if (in_leaf_r) begin
            if (alu_eq) state_nxt = ST_CLOSE;
          end else if (!c_cut && idx_r == HDR_LAST_IDX) begin
            state_nxt = ST_HDR_CHECK;
          end
        end
      end
      ST_HDR_CHECK: begin
        state_nxt = last_r ? ST_FINAL : ST_IDLE;
        if (is_root) begin
          if (id_r == ROOT_ID && !root_fail) state_nxt = ST_CLOSE;
        end else if (!chunk_fail) begin
          if (child_r == FLAG_W'(1) || size_r == '0) state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        state_nxt = last_r ? ST_FINAL : ST_IDLE;
        if (c_pop && open_r != LW'(1)) state_nxt = ST_CLOSE_LOAD;
      end
      ST_CLOSE_LOAD: begin
        state_nxt = ST_CLOSE;
      end
      ST_FINAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    hdr_start_nxt = hdr_start_r;
    id_nxt        = id_r;
    child_nxt     = child_r;
    hi_nz_nxt     = hi_nz_r;
    size_nxt      = size_r;
    in_leaf_nxt   = in_leaf_r;
    leaf_nxt      = leaf_r;
    open_nxt      = open_r;
    top_nxt       = top_r;
    err_kind_nxt  = err_kind_r;
    err_off_nxt   = err_off_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_kind_nxt  = out_kind_r;
    out_off_nxt   = out_off_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = end_pos;

    unique case (state_r)
      ST_IDLE: begin
        // capture the beat
        if (in_valid) begin
          byte_nxt = in_byte_value;
          last_nxt = in_last_byte;
        end
      end
      ST_CONSUME: begin
        // advance the stream, then check or absorb the byte
        pos_nxt = pos_r + P'(1);
        if (err_kind_r == ERR_NONE) begin
          if (c_extra) begin
            err_kind_nxt = ERR_EXTRA;
            err_off_nxt  = pos_r;
          end else if (in_leaf_r) begin
            leaf_nxt = alu_sum[SIZE_W-1:0];
            if (alu_eq) in_leaf_nxt = 1'b0;
          end else if (c_cut) begin
            err_kind_nxt = ERR_HDR_CUT;
            err_off_nxt  = pos_r;
          end else begin
            if (idx_r == '0) hdr_start_nxt = pos_r;
            case (idx_r) inside
              [4'd0:4'd3]:   id_nxt    = {id_r[ID_W-BYTE_W-1:0], byte_r};
              [4'd6:4'd7]:   child_nxt = {child_r[FLAG_W-BYTE_W-1:0], byte_r};
              4'd8:          hi_nz_nxt = byte_r != '0;
              [4'd9:4'd11]:  hi_nz_nxt = hi_nz_r || (byte_r != '0);
              [4'd12:4'd15]: size_nxt  = {size_r[SIZE_W-BYTE_W-1:0], byte_r};
              default: begin
              end
            endcase
            idx_nxt = idx_r + HDR_IDX_W'(1);
          end
        end
      end
      ST_HDR_CHECK: begin
        if (is_root) begin
          // root chunk opens the first level
          if (id_r != ROOT_ID) begin
            err_kind_nxt = ERR_ROOT_ID;
            err_off_nxt  = '0;
          end else if (root_fail) begin
            err_kind_nxt = ERR_ROOT_HDR;
            err_off_nxt  = '0;
          end else begin
            open_nxt  = LW'(1);
            top_nxt   = end_pos;
            mem_we    = 1'b1;
            mem_waddr = LW'(1);
          end
        end else if (chunk_fail) begin
          err_kind_nxt = chunk_kind;
          err_off_nxt  = hdr_start_r;
        end else if (child_r == FLAG_W'(1)) begin
          // push a new child list
          open_nxt  = open_r + LW'(1);
          top_nxt   = end_pos;
          mem_we    = 1'b1;
          mem_waddr = open_r + LW'(1);
        end else if (size_r != '0) begin
          in_leaf_nxt = 1'b1;
          leaf_nxt    = size_r;
        end
      end
      ST_CLOSE: begin
        // drop a level whose end is reached
        if (c_pop) open_nxt = open_r - LW'(1);
      end
      ST_CLOSE_LOAD: begin
        top_nxt = rd_data_r;
      end
      ST_FINAL: begin
        // hand over the verdict and clear for the next file
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = final_kind;
          out_off_nxt   = (final_kind == ERR_NONE) ? '0 : final_off_ext[OFF_W-1:0];
          pos_nxt       = '0;
          idx_nxt       = '0;
          in_leaf_nxt   = 1'b0;
          open_nxt      = '0;
          err_kind_nxt  = ERR_NONE;
          err_off_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      idx_r       <= '0;
      in_leaf_r   <= 1'b0;
      open_r      <= '0;
      err_kind_r  <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      in_leaf_r   <= in_leaf_nxt;
      open_r      <= open_nxt;
      err_kind_r  <= err_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hdr_start_r <= hdr_start_nxt;
    id_r        <= id_nxt;
    child_r     <= child_nxt;
    hi_nz_r     <= hi_nz_nxt;
    size_r      <= size_nxt;
    leaf_r      <= leaf_nxt;
    top_r       <= top_nxt;
    err_off_r   <= err_off_nxt;
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_off_r   <= out_off_nxt;
  end

  // level-end stack: one write port, registered read of the entry at the next open-level count
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= stack_mem[open_nxt];
  end

  assign in_stall         = state_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_kind_r == ERR_NONE;
  assign out_error_kind   = out_kind_r;
  assign out_error_offset = out_off_r;

  // nesting never exceeds the stack
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= LW'(MAX_NESTING))
    else $error("open level count beyond stack depth");

  // a verdict appears only out of the final step
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINAL))
    else $error("verdict raised outside final step");

  // an open leaf payload always has bytes left
  a_leaf_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_leaf_r |-> (leaf_r != '0))
    else $error("leaf payload open with no bytes left");

  // a latched violation holds until the verdict is formed
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (err_kind_r != ERR_NONE && state_r != ST_FINAL) |=> $stable(err_kind_r))
    else $error("first violation overwritten");

endmodule
